[rtl/chm_pkg.sv]
// chm_pkg: types, codes and sizes shared by the chained hash map core
// no dependencies; imported by chm_bucket_ram, chm_ctrl and the top level
`default_nettype none
package chm_pkg;

   localparam int Capacity  = 64;
   localparam int AddrBits  = $clog2(Capacity);
   localparam int KeyBits   = 32;
   localparam int ValueBits = 32;
   localparam int CountBits = AddrBits + 1;

   localparam logic [1:0] OP_LOOKUP = 2'd0;
   localparam logic [1:0] OP_INSERT = 2'd1;
   localparam logic [1:0] OP_REMOVE = 2'd2;
   localparam logic [1:0] OP_NONE   = 2'd3;

   localparam logic [2:0] STATUS_NOT_FOUND = 3'd0;
   localparam logic [2:0] STATUS_FOUND     = 3'd1;
   localparam logic [2:0] STATUS_INSERTED  = 3'd2;
   localparam logic [2:0] STATUS_UPDATED   = 3'd3;
   localparam logic [2:0] STATUS_REMOVED   = 3'd4;
   localparam logic [2:0] STATUS_FULL      = 3'd5;

   typedef enum logic [1:0] {
      MARK_EMPTY,
      MARK_SNUG,
      MARK_DISPLACED
   } mark_type;

   typedef struct packed {
      mark_type              mark;
      logic [KeyBits-1:0]    key;
      logic [ValueBits-1:0]  value;
      logic [AddrBits-1:0]   fwd;
      logic [AddrBits-1:0]   bwd;
      logic [AddrBits-1:0]   cho;
   } bucket_type;

   typedef struct packed {
      logic                rd_en;
      logic [AddrBits-1:0] rd_addr;
      logic                wr_en;
      logic [AddrBits-1:0] wr_addr;
      bucket_type          wr_data;
   } mem_req_type;

   typedef enum logic [1:0] {
      EDIT_FWD,
      EDIT_BWD,
      EDIT_CHO
   } edit_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_HOME,
      ST_WALK,
      ST_MISS,
      ST_PROBE,
      ST_HIT,
      ST_UNLINK,
      ST_EDIT,
      ST_PULL,
      ST_VAC_RD,
      ST_VAC,
      ST_RESP
   } state_type;

endpackage
`default_nettype wire

[rtl/chm_bucket_ram.sv]
// chm_bucket_ram: bucket memory, one write and one read port, registered read
// depends on chm_pkg; entries never written read back as an empty bucket
`default_nettype none
module chm_bucket_ram (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  chm_pkg::mem_req_type      mem_req,
   output chm_pkg::bucket_type       rd_data
);
   import chm_pkg::*;

   bucket_type           mem [Capacity];
   logic [Capacity-1:0]  written_ff;
   bucket_type           rdata_ff;
   logic                 rvalid_ff;

   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         mem[mem_req.wr_addr] <= mem_req.wr_data;
      end
      if (mem_req.rd_en) begin
         rdata_ff <= mem[mem_req.rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         written_ff <= '0;
         rvalid_ff  <= 1'b0;
      end else begin
         if (mem_req.wr_en) begin
            written_ff[mem_req.wr_addr] <= 1'b1;
         end
         if (mem_req.rd_en) begin
            rvalid_ff <= written_ff[mem_req.rd_addr];
         end
      end
   end

   assign rd_data = rvalid_ff ? rdata_ff : '0;

endmodule
`default_nettype wire

[rtl/chm_ctrl.sv]
// chm_ctrl: request sequencer walking chains, probing and splicing in bucket memory
// depends on chm_pkg; drives chm_bucket_ram through one mem_req_type bundle
`default_nettype none
module chm_ctrl (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_ready,
   input  wire logic [1:0]                  req_op,
   input  wire logic [chm_pkg::KeyBits-1:0]   req_key,
   input  wire logic [chm_pkg::ValueBits-1:0] req_value,
   output logic                             rsp_valid,
   input  wire logic                        rsp_ready,
   output logic [2:0]                       rsp_status,
   output logic [chm_pkg::ValueBits-1:0]    rsp_found_value,
   input  wire logic                        csr_valid,
   output logic                             csr_ready,
   input  wire logic [chm_pkg::CountBits-1:0] csr_data,
   output chm_pkg::mem_req_type             mem_req,
   input  chm_pkg::bucket_type              rd_data
);
   import chm_pkg::*;

   localparam logic [CountBits-1:0] CapCount = CountBits'(Capacity);
   localparam logic [CountBits-1:0] LastStep = CountBits'(Capacity - 1);

   state_type               state_ff, state_in, ret_ff, ret_in;
   logic [1:0]              op_ff, op_in;
   logic [KeyBits-1:0]      key_ff, key_in;
   logic [ValueBits-1:0]    val_ff, val_in;
   logic [AddrBits-1:0]     q_ff, q_in, p_ff, p_in, s_ff, s_in;
   logic [AddrBits-1:0]     dst_ff, dst_in, pull_cho_ff, pull_cho_in;
   logic [AddrBits-1:0]     edit_addr_ff, edit_addr_in, edit_val_ff, edit_val_in;
   edit_type                edit_kind_ff, edit_kind_in;
   logic [CountBits-1:0]    n_ff, n_in, count_ff, count_in;
   logic [CountBits-1:0]    max_ff;
   logic                    has_chain_ff, has_chain_in, home_empty_ff, home_empty_in;
   bucket_type              prec_ff, prec_in;
   logic [2:0]              status_ff, status_in, rsp_status_ff, rsp_status_in;
   logic [ValueBits-1:0]    fv_ff, fv_in, rsp_fv_ff, rsp_fv_in;
   logic                    rsp_valid_ff, rsp_valid_in;

   logic [AddrBits-1:0]     home, nx, pv, jaddr, nx2;
   bucket_type              wrec;

   assign home  = key_ff[AddrBits-1:0];
   assign nx    = p_ff + prec_ff.fwd;
   assign pv    = p_ff - prec_ff.bwd;
   assign jaddr = q_ff + n_ff[AddrBits-1:0];
   assign nx2   = s_ff + rd_data.fwd;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         max_ff       <= CountBits'(48);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid) begin
            max_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      ret_ff        <= ret_in;
      op_ff         <= op_in;
      key_ff        <= key_in;
      val_ff        <= val_in;
      q_ff          <= q_in;
      p_ff          <= p_in;
      s_ff          <= s_in;
      dst_ff        <= dst_in;
      pull_cho_ff   <= pull_cho_in;
      edit_addr_ff  <= edit_addr_in;
      edit_val_ff   <= edit_val_in;
      edit_kind_ff  <= edit_kind_in;
      n_ff          <= n_in;
      has_chain_ff  <= has_chain_in;
      home_empty_ff <= home_empty_in;
      prec_ff       <= prec_in;
      status_ff     <= status_in;
      fv_ff         <= fv_in;
      rsp_status_ff <= rsp_status_in;
      rsp_fv_ff     <= rsp_fv_in;
   end

   always_comb begin
      state_in      = state_ff;
      ret_in        = ret_ff;
      op_in         = op_ff;
      key_in        = key_ff;
      val_in        = val_ff;
      q_in          = q_ff;
      p_in          = p_ff;
      s_in          = s_ff;
      dst_in        = dst_ff;
      pull_cho_in   = pull_cho_ff;
      edit_addr_in  = edit_addr_ff;
      edit_val_in   = edit_val_ff;
      edit_kind_in  = edit_kind_ff;
      n_in          = n_ff;
      has_chain_in  = has_chain_ff;
      home_empty_in = home_empty_ff;
      prec_in       = prec_ff;
      status_in     = status_ff;
      fv_in         = fv_ff;
      count_in      = count_ff;
      rsp_status_in = rsp_status_ff;
      rsp_fv_in     = rsp_fv_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      req_ready     = 1'b0;
      wrec          = rd_data;
      mem_req       = '0;

      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               op_in     = req_op;
               key_in    = req_key;
               val_in    = req_value;
               status_in = STATUS_NOT_FOUND;
               fv_in     = '0;
               if (req_op == OP_NONE) begin
                  state_in = ST_RESP;
               end else begin
                  mem_req.rd_en   = 1'b1;
                  mem_req.rd_addr = req_key[AddrBits-1:0];
                  state_in        = ST_HOME;
               end
            end
         end

         ST_HOME: begin
            home_empty_in = (rd_data.mark == MARK_EMPTY);
            n_in          = '0;
            if (rd_data.mark == MARK_SNUG ||
                (rd_data.mark == MARK_DISPLACED && rd_data.cho != '0)) begin
               has_chain_in    = 1'b1;
               q_in            = (rd_data.mark == MARK_SNUG) ? home : home + rd_data.cho;
               mem_req.rd_en   = 1'b1;
               mem_req.rd_addr = q_in;
               state_in        = ST_WALK;
            end else begin
               has_chain_in = 1'b0;
               q_in         = home;
               state_in     = ST_MISS;
            end
         end

         ST_WALK: begin
            if (rd_data.mark != MARK_EMPTY && rd_data.key == key_ff) begin
               p_in     = q_ff;
               prec_in  = rd_data;
               state_in = ST_HIT;
            end else if (rd_data.fwd == '0) begin
               state_in = ST_MISS;
            end else begin
               q_in = q_ff + rd_data.fwd;
               if (n_ff == LastStep) begin
                  state_in = ST_MISS;
               end else begin
                  n_in            = n_ff + 1'b1;
                  mem_req.rd_en   = 1'b1;
                  mem_req.rd_addr = q_in;
               end
            end
         end

         ST_MISS: begin
            state_in = ST_RESP;
            if (op_ff == OP_INSERT) begin
               if (count_ff >= max_ff || count_ff >= CapCount) begin
                  status_in = STATUS_FULL;
               end else if (home_empty_ff) begin
                  mem_req.wr_en   = 1'b1;
                  mem_req.wr_addr = home;
                  mem_req.wr_data = '{mark: MARK_SNUG, key: key_ff, value: val_ff,
                                      fwd: '0, bwd: '0, cho: '0};
                  count_in        = count_ff + 1'b1;
                  status_in       = STATUS_INSERTED;
               end else begin
                  // probe from the chain tail, or from home when there is no chain
                  n_in            = CountBits'(1);
                  mem_req.rd_en   = 1'b1;
                  mem_req.rd_addr = q_ff + 1'b1;
                  state_in        = ST_PROBE;
               end
            end
         end

         ST_PROBE: begin
            if (rd_data.mark == MARK_EMPTY) begin
               mem_req.wr_en   = 1'b1;
               mem_req.wr_addr = jaddr;
               mem_req.wr_data = '{mark: MARK_DISPLACED, key: key_ff, value: val_ff,
                                   fwd: '0,
                                   bwd: has_chain_ff ? n_ff[AddrBits-1:0] : '0,
                                   cho: rd_data.cho};
               count_in        = count_ff + 1'b1;
               status_in       = STATUS_INSERTED;
               // link the new slot from the tail or from home
               mem_req.rd_en   = 1'b1;
               mem_req.rd_addr = q_ff;
               edit_addr_in    = q_ff;
               edit_kind_in    = has_chain_ff ? EDIT_FWD : EDIT_CHO;
               edit_val_in     = n_ff[AddrBits-1:0];
               ret_in          = ST_RESP;
               state_in        = ST_EDIT;
            end else if (n_ff == CapCount) begin
               status_in = STATUS_FULL;
               state_in  = ST_RESP;
            end else begin
               n_in            = n_ff + 1'b1;
               mem_req.rd_en   = 1'b1;
               mem_req.rd_addr = jaddr + 1'b1;
            end
         end

         ST_HIT: begin
            case (op_ff)
               OP_LOOKUP: begin
                  status_in = STATUS_FOUND;
                  fv_in     = prec_ff.value;
                  state_in  = ST_RESP;
               end
               OP_INSERT: begin
                  wrec            = prec_ff;
                  wrec.value      = val_ff;
                  mem_req.wr_en   = 1'b1;
                  mem_req.wr_addr = p_ff;
                  mem_req.wr_data = wrec;
                  status_in       = STATUS_UPDATED;
                  state_in        = ST_RESP;
               end
               default: begin
                  status_in = STATUS_REMOVED;
                  n_in      = '0;
                  s_in      = p_ff;
                  if (prec_ff.mark == MARK_SNUG) begin
                     if (prec_ff.fwd != '0) begin
                        dst_in          = p_ff;
                        s_in            = nx;
                        pull_cho_in     = prec_ff.cho;
                        mem_req.rd_en   = 1'b1;
                        mem_req.rd_addr = nx;
                        state_in        = ST_PULL;
                     end else begin
                        state_in = ST_VAC_RD;
                     end
                  end else begin
                     // splice: predecessor forward link, or home chain start
                     mem_req.rd_en = 1'b1;
                     ret_in        = ST_UNLINK;
                     state_in      = ST_EDIT;
                     if (prec_ff.bwd != '0) begin
                        edit_addr_in = pv;
                        edit_kind_in = EDIT_FWD;
                        edit_val_in  = (prec_ff.fwd != '0) ? prec_ff.bwd + prec_ff.fwd : '0;
                     end else begin
                        edit_addr_in = home;
                        edit_kind_in = EDIT_CHO;
                        edit_val_in  = (prec_ff.fwd != '0) ? nx - home : '0;
                     end
                     mem_req.rd_addr = edit_addr_in;
                  end
               end
            endcase
         end

         ST_UNLINK: begin
            if (prec_ff.fwd != '0) begin
               mem_req.rd_en   = 1'b1;
               mem_req.rd_addr = nx;
               edit_addr_in    = nx;
               edit_kind_in    = EDIT_BWD;
               edit_val_in     = (prec_ff.bwd != '0) ? prec_ff.bwd + prec_ff.fwd : '0;
               ret_in          = ST_VAC_RD;
               state_in        = ST_EDIT;
            end else begin
               state_in = ST_VAC_RD;
            end
         end

         ST_EDIT: begin
            case (edit_kind_ff)
               EDIT_FWD: wrec.fwd = edit_val_ff;
               EDIT_BWD: wrec.bwd = edit_val_ff;
               default:  wrec.cho = edit_val_ff;
            endcase
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = edit_addr_ff;
            mem_req.wr_data = wrec;
            state_in        = ret_ff;
         end

         ST_PULL: begin
            // source entry becomes the snug head at dst
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = dst_ff;
            mem_req.wr_data = '{mark: MARK_SNUG, key: rd_data.key, value: rd_data.value,
                                fwd: (rd_data.fwd != '0) ? nx2 - dst_ff : '0,
                                bwd: '0, cho: pull_cho_ff};
            if (rd_data.fwd != '0) begin
               mem_req.rd_en   = 1'b1;
               mem_req.rd_addr = nx2;
               edit_addr_in    = nx2;
               edit_kind_in    = EDIT_BWD;
               edit_val_in     = nx2 - dst_ff;
               ret_in          = ST_VAC_RD;
               state_in        = ST_EDIT;
            end else begin
               state_in = ST_VAC_RD;
            end
         end

         ST_VAC_RD: begin
            mem_req.rd_en   = 1'b1;
            mem_req.rd_addr = s_ff;
            state_in        = ST_VAC;
         end

         ST_VAC: begin
            if (rd_data.cho != '0 && n_ff < CapCount) begin
               n_in            = n_ff + 1'b1;
               dst_in          = s_ff;
               s_in            = s_ff + rd_data.cho;
               pull_cho_in     = '0;
               mem_req.rd_en   = 1'b1;
               mem_req.rd_addr = s_in;
               state_in        = ST_PULL;
            end else begin
               wrec            = rd_data;
               wrec.mark       = MARK_EMPTY;
               wrec.fwd        = '0;
               wrec.bwd        = '0;
               mem_req.wr_en   = 1'b1;
               mem_req.wr_addr = s_ff;
               mem_req.wr_data = wrec;
               if (count_ff != '0) begin
                  count_in = count_ff - 1'b1;
               end
               state_in = ST_RESP;
            end
         end

         ST_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_fv_in     = fv_ff;
               state_in      = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_found_value = rsp_fv_ff;
   assign csr_ready       = 1'b1;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CapCount) else $error("entry count above capacity");
   a_no_write_idle: assert property (@(posedge clock) disable iff (reset)
      mem_req.wr_en |-> state_ff != ST_IDLE) else $error("memory write while idle");
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> state_ff != ST_IDLE) else $error("accept did not start");
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |=> $stable(count_ff)) else $error("count moved while idle");

endmodule
`default_nettype wire

[rtl/chained_open_hash_map_core.sv]
// chained_open_hash_map_core: top level of the coalesced-chain hash map
// depends on chm_pkg, chm_bucket_ram and chm_ctrl
//
//   channel   ports                           direction  width of payload
//   req       req_op, req_key, req_value      in         2 / 32 / 32
//   rsp       rsp_status, rsp_found_value     out        3 / 32
//   csr       csr_data (max_entries)          in         7
//
// one request at a time; a miss on an empty home reads only the home bucket, and further steps
// come per chain bucket read, per slot probed, per link rewritten, to free a bucket on remove
// and per bucket pulled forward
// the bucket memory read (registered, one read and one write port) sets the pace
// reset clears count and per-bucket written flags and sets the limit to 48
// a result waiting on rsp does not stop the next request from being taken
`default_nettype none
module chained_open_hash_map_core (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic [1:0]                    req_op,
   input  wire logic [chm_pkg::KeyBits-1:0]   req_key,
   input  wire logic [chm_pkg::ValueBits-1:0] req_value,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic [2:0]                         rsp_status,
   output logic [chm_pkg::ValueBits-1:0]      rsp_found_value,
   input  wire logic                          csr_valid,
   output logic                               csr_ready,
   input  wire logic [chm_pkg::CountBits-1:0] csr_data
);
   import chm_pkg::*;

   mem_req_type mem_req;
   bucket_type  rd_data;

   chm_bucket_ram u_ram (
      .clock   (clock),
      .reset   (reset),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

   chm_ctrl u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_op          (req_op),
      .req_key         (req_key),
      .req_value       (req_value),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_status      (rsp_status),
      .rsp_found_value (rsp_found_value),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_data        (csr_data),
      .mem_req         (mem_req),
      .rd_data         (rd_data)
   );

endmodule
`default_nettype wire
